FILE: rtl/gtd_pkg.sv
`timescale 1ns / 1ps

package gtd_pkg;

    localparam int ACC_WIDTH_DEF  = 40;
    localparam int COEFF_FRAC_DEF = 14;
    localparam int MAX_BLOCK_DEF  = 1023;

    localparam int SAMPLE_W   = 16;
    localparam int COEFF_W    = 16;
    localparam int THRESH_W   = 48;
    localparam int BLEN_W     = 10;
    localparam int HOLD_W     = 4;
    localparam int MAG_W      = 63;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = THRESH_W;
    localparam int BLEN_MAX   = (1 << BLEN_W) - 1;

    // multiplier digit size for the wide products
    localparam int DIGIT_W  = 16;
    localparam int DIGIT_SH = $clog2(DIGIT_W);

    localparam logic [CFG_IDX_W-1:0] REG_COEFF        = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_BLOCKS  = CFG_IDX_W'(3);

    localparam logic [COEFF_W-1:0]  COEFF_RST        = '0;
    localparam logic [THRESH_W-1:0] THRESHOLD_RST    = 48'd250000000000;
    localparam logic [BLEN_W-1:0]   BLOCK_LENGTH_RST = 10'd205;
    localparam logic [HOLD_W-1:0]   HOLD_BLOCKS_RST  = 4'd3;

    typedef struct packed {
        logic [COEFF_W-1:0]  coeff;
        logic [THRESH_W-1:0] threshold;
        logic [BLEN_W-1:0]   block_length;
        logic [HOLD_W-1:0]   hold_blocks;
    } cfg_t;

    typedef enum logic [2:0] {
        JC_NEXT     = 3'd0,
        JC_WAIT_IN  = 3'd1,
        JC_BLOCK    = 3'd2,
        JC_LOOP     = 3'd3,
        JC_WAIT_OUT = 3'd4,
        JC_JUMP     = 3'd5
    } jc_t;

    typedef enum logic [1:0] {
        YLD_NONE   = 2'd0,
        YLD_RECENT = 2'd1,
        YLD_OLDER  = 2'd2,
        YLD_RC     = 2'd3
    } yld_t;

    localparam int UPC_W = 4;

    localparam logic [UPC_W-1:0] UA_IDLE    = UPC_W'(0);
    localparam logic [UPC_W-1:0] UA_REC_MUL = UPC_W'(1);
    localparam logic [UPC_W-1:0] UA_REC     = UPC_W'(2);
    localparam logic [UPC_W-1:0] UA_MAG_RC  = UPC_W'(3);
    localparam logic [UPC_W-1:0] UA_LD_RC   = UPC_W'(4);
    localparam logic [UPC_W-1:0] UA_SQ_R    = UPC_W'(5);
    localparam logic [UPC_W-1:0] UA_LD_O    = UPC_W'(6);
    localparam logic [UPC_W-1:0] UA_SQ_O    = UPC_W'(7);
    localparam logic [UPC_W-1:0] UA_LD_Y_RC = UPC_W'(8);
    localparam logic [UPC_W-1:0] UA_CROSS   = UPC_W'(9);
    localparam logic [UPC_W-1:0] UA_DRAIN   = UPC_W'(10);
    localparam logic [UPC_W-1:0] UA_CLAMP   = UPC_W'(11);
    localparam logic [UPC_W-1:0] UA_EMIT    = UPC_W'(12);

    typedef struct packed {
        jc_t              jc;
        logic [UPC_W-1:0] target;
        logic             ld_sample;
        logic             x_older;
        logic             y_digit;
        logic             acc_en;
        logic             acc_sq;
        logic             acc_neg;
        yld_t             y_ld;
        logic             dig_step;
        logic             ld_rc;
        logic             rec;
        logic             clr_tot;
        logic             clamp;
        logic             emit;
    } ctrl_t;

    typedef struct packed {
        logic block_done;
        logic last_digit;
    } stat_t;

    // control store
    function automatic ctrl_t ucode(input logic [UPC_W-1:0] addr);
        ctrl_t w;
        w        = '0;
        w.jc     = JC_NEXT;
        w.target = UA_IDLE;
        w.y_ld   = YLD_NONE;
        case (addr)
            UA_IDLE: begin
                w.ld_sample = 1'b1;
                w.jc        = JC_WAIT_IN;
            end
            UA_REC_MUL: begin
                w.jc = JC_NEXT;
            end
            UA_REC: begin
                w.rec    = 1'b1;
                w.jc     = JC_BLOCK;
                w.target = UA_IDLE;
            end
            UA_MAG_RC: begin
                w.y_ld    = YLD_RECENT;
                w.clr_tot = 1'b1;
            end
            UA_LD_RC: begin
                w.ld_rc = 1'b1;
            end
            UA_SQ_R: begin
                w.y_digit  = 1'b1;
                w.acc_en   = 1'b1;
                w.acc_sq   = 1'b1;
                w.dig_step = 1'b1;
                w.jc       = JC_LOOP;
                w.target   = UA_SQ_R;
            end
            UA_LD_O: begin
                w.y_ld = YLD_OLDER;
            end
            UA_SQ_O: begin
                w.x_older  = 1'b1;
                w.y_digit  = 1'b1;
                w.acc_en   = 1'b1;
                w.acc_sq   = 1'b1;
                w.dig_step = 1'b1;
                w.jc       = JC_LOOP;
                w.target   = UA_SQ_O;
            end
            UA_LD_Y_RC: begin
                w.y_ld = YLD_RC;
            end
            UA_CROSS: begin
                w.x_older  = 1'b1;
                w.y_digit  = 1'b1;
                w.acc_en   = 1'b1;
                w.acc_neg  = 1'b1;
                w.dig_step = 1'b1;
                w.jc       = JC_LOOP;
                w.target   = UA_CROSS;
            end
            UA_DRAIN: begin
                w.jc = JC_NEXT;
            end
            UA_CLAMP: begin
                w.clamp = 1'b1;
            end
            UA_EMIT: begin
                w.emit   = 1'b1;
                w.jc     = JC_WAIT_OUT;
                w.target = UA_IDLE;
            end
            default: begin
                w.jc     = JC_JUMP;
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/gtd_datapath.sv
`timescale 1ns / 1ps

module gtd_datapath
    import gtd_pkg::*;
#(
    parameter int ACC_WIDTH       = ACC_WIDTH_DEF,
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_DEF,
    parameter int MAX_BLOCK_LEN   = MAX_BLOCK_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cfg_t                       cfg,
    input  ctrl_t                      ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    output stat_t                      stat,
    output logic [MAG_W-1:0]           magnitude_sq,
    output logic                       tone_present,
    output logic                       changed
);

    localparam int YOP_W = DIGIT_W + 1;
    localparam int PW    = ACC_WIDTH + YOP_W;
    localparam int ND    = (PW + DIGIT_W - 1) / DIGIT_W;
    localparam int YW    = ND * DIGIT_W;
    localparam int DIG_W = $clog2(ND);
    localparam int RW    = PW + 2;
    localparam int TW    = 2 * ACC_WIDTH + COEFF_FRAC_BITS + 6;
    localparam int SH_W  = $clog2(YW + COEFF_FRAC_BITS + 1);

    localparam logic [BLEN_W-1:0] LEN_CAP =
        BLEN_W'((MAX_BLOCK_LEN > BLEN_MAX) ? BLEN_MAX : MAX_BLOCK_LEN);
    localparam logic signed [RW-1:0] RND_HALF = RW'(1) << (COEFF_FRAC_BITS - 1);

    typedef struct packed {
        logic             acc_en;
        logic             sq;
        logic             neg;
        logic [DIG_W-1:0] dig;
    } acc_tag_t;

    logic signed [SAMPLE_W-1:0]  sample_reg;
    logic signed [ACC_WIDTH-1:0] recent_reg;
    logic signed [ACC_WIDTH-1:0] older_reg;
    logic [BLEN_W-1:0]           count_reg;
    logic [HOLD_W-1:0]           hold_reg;
    logic [YW-1:0]               y_reg;
    logic [DIG_W-1:0]            dig_reg;
    logic signed [PW-1:0]        prod_reg;
    acc_tag_t                    tag_reg;
    acc_tag_t                    tag_next;
    logic signed [PW-1:0]        rc_reg;
    logic signed [TW-1:0]        tot_reg;
    logic [MAG_W-1:0]            mag_reg;
    logic [MAG_W-1:0]            out_mag_reg;
    logic                        out_tone_reg;
    logic                        out_changed_reg;

    logic                        last_digit;
    logic signed [ACC_WIDTH-1:0] x_op;
    logic signed [YOP_W-1:0]     y_op;
    logic signed [PW-1:0]        prod_next;

    logic signed [RW-1:0]        rnd_sum;
    logic signed [RW-1:0]        rnd_shr;
    logic signed [RW-1:0]        older_ext;
    logic signed [RW-1:0]        sample_ext;
    logic signed [RW-1:0]        rec_wide;
    logic                        rec_ovf;
    logic signed [ACC_WIDTH-1:0] rec_sat;

    logic [BLEN_W-1:0]           len_eff;
    logic [BLEN_W-1:0]           cnt_inc;

    logic [SH_W-1:0]             shamt;
    logic [TW-1:0]               prod_ext;
    logic [TW-1:0]               addend;
    logic signed [TW-1:0]        tot_shr;
    logic [MAG_W-1:0]            mag_clamp;

    logic [HOLD_W-1:0]           hold_eff;
    logic                        loud;
    logic [HOLD_W-1:0]           hold_next;

    // shared multiplier: accumulator times coefficient or one 16-bit digit
    assign last_digit = (dig_reg == DIG_W'(ND - 1));
    assign x_op       = ctrl.x_older ? older_reg : recent_reg;
    assign y_op       = ctrl.y_digit ? {last_digit & y_reg[DIGIT_W-1], y_reg[DIGIT_W-1:0]}
                                     : {cfg.coeff[COEFF_W-1], cfg.coeff};
    assign prod_next  = x_op * y_op;

    // recurrence with round half up and saturation
    assign rnd_sum    = {{(RW-PW){prod_reg[PW-1]}}, prod_reg} + RND_HALF;
    assign rnd_shr    = rnd_sum >>> COEFF_FRAC_BITS;
    assign older_ext  = {{(RW-ACC_WIDTH){older_reg[ACC_WIDTH-1]}}, older_reg};
    assign sample_ext = {{(RW-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
    assign rec_wide   = rnd_shr - older_ext + sample_ext;
    assign rec_ovf    = (rec_wide[RW-1:ACC_WIDTH-1] != {(RW-ACC_WIDTH+1){rec_wide[RW-1]}});
    assign rec_sat    = rec_ovf ? {rec_wide[RW-1], {(ACC_WIDTH-1){~rec_wide[RW-1]}}}
                                : rec_wide[ACC_WIDTH-1:0];

    always_comb begin
        if (cfg.block_length == '0) begin
            len_eff = BLEN_W'(1);
        end else if (cfg.block_length > LEN_CAP) begin
            len_eff = LEN_CAP;
        end else begin
            len_eff = cfg.block_length;
        end
    end

    assign cnt_inc         = count_reg + BLEN_W'(1);
    assign stat.block_done = (cnt_inc >= len_eff);
    assign stat.last_digit = last_digit;

    // digit products land at 16*digit, squares one more F bits up
    assign shamt    = (SH_W'(tag_reg.dig) << DIGIT_SH)
                    + (tag_reg.sq ? SH_W'(COEFF_FRAC_BITS) : SH_W'(0));
    assign prod_ext = {{(TW-PW){prod_reg[PW-1]}}, prod_reg};
    assign addend   = prod_ext << shamt;

    assign tot_shr = tot_reg >>> COEFF_FRAC_BITS;

    always_comb begin
        if (tot_shr[TW-1]) begin
            mag_clamp = '0;
        end else if (|tot_shr[TW-2:MAG_W]) begin
            mag_clamp = '1;
        end else begin
            mag_clamp = tot_shr[MAG_W-1:0];
        end
    end

    assign hold_eff  = (cfg.hold_blocks == '0) ? HOLD_W'(1) : cfg.hold_blocks;
    assign loud      = (mag_reg >= MAG_W'(cfg.threshold));
    assign hold_next = loud ? hold_eff
                     : ((hold_reg != '0) ? hold_reg - HOLD_W'(1) : hold_reg);

    assign tag_next.acc_en = ctrl.acc_en;
    assign tag_next.sq     = ctrl.acc_sq;
    assign tag_next.neg    = ctrl.acc_neg;
    assign tag_next.dig    = dig_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg <= '0;
            older_reg  <= '0;
            count_reg  <= '0;
            hold_reg   <= '0;
            dig_reg    <= '0;
            tag_reg    <= '0;
        end else begin
            tag_reg <= tag_next;
            if (ctrl.rec) begin
                older_reg  <= recent_reg;
                recent_reg <= rec_sat;
                count_reg  <= stat.block_done ? '0 : cnt_inc;
            end
            if (ctrl.emit) begin
                recent_reg <= '0;
                older_reg  <= '0;
                hold_reg   <= hold_next;
            end
            if (ctrl.y_ld != YLD_NONE) begin
                dig_reg <= '0;
            end else if (ctrl.dig_step) begin
                dig_reg <= last_digit ? '0 : dig_reg + DIG_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (ctrl.ld_sample) begin
            sample_reg <= sample;
        end
        if (ctrl.ld_rc) begin
            rc_reg <= prod_reg;
        end
        case (ctrl.y_ld)
            YLD_RECENT: y_reg <= {{(YW-ACC_WIDTH){recent_reg[ACC_WIDTH-1]}}, recent_reg};
            YLD_OLDER:  y_reg <= {{(YW-ACC_WIDTH){older_reg[ACC_WIDTH-1]}}, older_reg};
            YLD_RC:     y_reg <= {{(YW-PW){rc_reg[PW-1]}}, rc_reg};
            YLD_NONE: begin
                if (ctrl.dig_step) begin
                    y_reg <= y_reg >> DIGIT_W;
                end
            end
        endcase
        if (ctrl.clr_tot) begin
            tot_reg <= '0;
        end else if (tag_reg.acc_en) begin
            tot_reg <= tag_reg.neg ? tot_reg - addend : tot_reg + addend;
        end
        if (ctrl.clamp) begin
            mag_reg <= mag_clamp;
        end
        if (ctrl.emit) begin
            out_mag_reg     <= mag_reg;
            out_tone_reg    <= (hold_next != '0);
            out_changed_reg <= ((hold_next != '0) != (hold_reg != '0));
        end
    end

    assign magnitude_sq = out_mag_reg;
    assign tone_present = out_tone_reg;
    assign changed      = out_changed_reg;

    a_count_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.rec && !stat.block_done |=> count_reg != '0)
        else $error("sample count lost within a block");

    a_tone_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |=> tone_present == (hold_reg != '0))
        else $error("tone flag disagrees with hold count");

    a_edge_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |=> changed == (tone_present != $past(hold_reg != '0)))
        else $error("changed flag does not mark a tone edge");

endmodule

FILE: rtl/goertzel_tone_detector_unit.sv
`timescale 1ns / 1ps

// Single-bin Goertzel tone detector. A sample is accepted, multiplied and then
// used to update the recurrence; the sample that closes a block also runs the
// magnitude steps, ND being the number of 16-bit digits of an ACC_WIDTH+17 bit
// product (ND = 4 at the default width), because the three magnitude terms go digit by digit
// through the one 17 x ACC_WIDTH multiplier under the microcode sequencer.
// The result sits in an output register, so new samples are taken while it
// waits; only the end of the next block waits for it to be taken.
// Configuration writes are accepted only while the sequencer is idle.

module goertzel_tone_detector_unit
    import gtd_pkg::*;
#(
    parameter int ACC_WIDTH       = ACC_WIDTH_DEF,
    parameter int COEFF_FRAC_BITS = COEFF_FRAC_DEF,
    parameter int MAX_BLOCK_LEN   = MAX_BLOCK_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [MAG_W-1:0]           m_magnitude_sq,
    output logic                       m_tone_present,
    output logic                       m_changed,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    ctrl_t            word;
    ctrl_t            ctrl;
    stat_t            stat;
    logic             in_take;
    logic             out_free;

    assign s_ready   = (upc_reg == UA_IDLE);
    assign in_take   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign cfg_ready = (upc_reg == UA_IDLE);

    assign word = ucode(upc_reg);

    always_comb begin
        ctrl           = word;
        ctrl.ld_sample = word.ld_sample & s_valid;
        ctrl.emit      = word.emit & out_free;
    end

    // sequencer
    always_comb begin
        unique case (word.jc)
            JC_NEXT:     upc_next = upc_reg + UPC_W'(1);
            JC_WAIT_IN:  upc_next = in_take ? upc_reg + UPC_W'(1) : upc_reg;
            JC_BLOCK:    upc_next = stat.block_done ? upc_reg + UPC_W'(1) : word.target;
            JC_LOOP:     upc_next = stat.last_digit ? upc_reg + UPC_W'(1) : word.target;
            JC_WAIT_OUT: upc_next = out_free ? word.target : upc_reg;
            JC_JUMP:     upc_next = word.target;
            default:     upc_next = UA_IDLE;
        endcase
    end

    always_comb begin
        if (ctrl.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_COEFF:        cfg_next.coeff        = cfg_data[COEFF_W-1:0];
                REG_THRESHOLD:    cfg_next.threshold    = cfg_data[THRESH_W-1:0];
                REG_BLOCK_LENGTH: cfg_next.block_length = cfg_data[BLEN_W-1:0];
                REG_HOLD_BLOCKS:  cfg_next.hold_blocks  = cfg_data[HOLD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg              <= UA_IDLE;
            m_valid_reg          <= 1'b0;
            cfg_reg.coeff        <= COEFF_RST;
            cfg_reg.threshold    <= THRESHOLD_RST;
            cfg_reg.block_length <= BLOCK_LENGTH_RST;
            cfg_reg.hold_blocks  <= HOLD_BLOCKS_RST;
        end else begin
            upc_reg     <= upc_next;
            m_valid_reg <= m_valid_next;
            cfg_reg     <= cfg_next;
        end
    end

    gtd_datapath #(
        .ACC_WIDTH       (ACC_WIDTH),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
        .MAX_BLOCK_LEN   (MAX_BLOCK_LEN)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .ctrl         (ctrl),
        .sample       (s_sample),
        .stat         (stat),
        .magnitude_sq (m_magnitude_sq),
        .tone_present (m_tone_present),
        .changed      (m_changed)
    );

    a_take_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> upc_reg == UA_REC_MUL)
        else $error("accepted sample did not start the recurrence");

    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        upc_reg == UA_EMIT && !out_free |=> upc_reg == UA_EMIT && m_valid_reg)
        else $error("sequencer left emit step while result still pending");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_magnitude_sq)
            && $stable(m_tone_present) && $stable(m_changed))
        else $error("pending result transaction changed before it was taken");

endmodule

FILE: bench/gtd_block_checker.sv
`timescale 1ns / 1ps

module gtd_block_checker
    import gtd_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [MAG_W-1:0]           m_magnitude_sq,
    input  logic                       m_tone_present,
    input  logic                       m_changed,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int                         fail_count,
    output int                         pending
);

    localparam int ACC_W = ACC_WIDTH_DEF;
    localparam int FRAC  = COEFF_FRAC_DEF;

    localparam logic signed [63:0]  ACC_HI     = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
    localparam logic signed [63:0]  ACC_LO     = -ACC_HI - 64'sd1;
    localparam logic signed [63:0]  ROUND_HALF = 64'sd1 <<< (FRAC - 1);
    localparam logic signed [127:0] MAG_HI     = (128'sd1 <<< MAG_W) - 128'sd1;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude_sq;
        logic             tone_present;
        logic             changed;
    } block_result_t;

    cfg_t                    regs;
    logic signed [ACC_W-1:0] recent;
    logic signed [ACC_W-1:0] older;
    logic [BLEN_W-1:0]       count;
    logic [HOLD_W-1:0]       hold_left;
    block_result_t           expected_blocks[$];
    int                      mismatches = 0;

    // one step of the recurrence, closing the block when the count is reached
    task automatic take_sample(input logic signed [SAMPLE_W-1:0] smp);
        logic signed [63:0]  c;
        logic signed [63:0]  p;
        logic signed [63:0]  nv;
        logic signed [127:0] r_w;
        logic signed [127:0] o_w;
        logic signed [127:0] c_w;
        logic signed [127:0] t;
        logic [BLEN_W-1:0]   eff_len;
        logic [HOLD_W-1:0]   reload;
        logic [MAG_W-1:0]    mag;
        logic                was_on;
        block_result_t       res;
        c  = signed'(regs.coeff);
        p  = c * recent + ROUND_HALF;
        nv = (p >>> FRAC) - older + smp;
        if (nv > ACC_HI) begin
            nv = ACC_HI;
        end else if (nv < ACC_LO) begin
            nv = ACC_LO;
        end
        older  = recent;
        recent = nv[ACC_W-1:0];
        count  = count + 1'b1;
        eff_len = (regs.block_length == '0) ? BLEN_W'(1) : regs.block_length;
        if (count >= eff_len) begin
            r_w = recent;
            o_w = older;
            c_w = c;
            t = ((r_w * r_w) <<< FRAC) + ((o_w * o_w) <<< FRAC) - r_w * c_w * o_w;
            t = t >>> FRAC;
            if (t < 0) begin
                mag = '0;
            end else if (t > MAG_HI) begin
                mag = '1;
            end else begin
                mag = t[MAG_W-1:0];
            end
            was_on = (hold_left != '0);
            reload = (regs.hold_blocks == '0) ? HOLD_W'(1) : regs.hold_blocks;
            if (mag >= regs.threshold) begin
                hold_left = reload;
            end else if (hold_left != '0) begin
                hold_left = hold_left - 1'b1;
            end
            res.magnitude_sq = mag;
            res.tone_present = (hold_left != '0);
            res.changed      = (hold_left != '0) != was_on;
            expected_blocks.push_back(res);
            recent = '0;
            older  = '0;
            count  = '0;
        end
    endtask

    task automatic check_result();
        block_result_t want;
        if (expected_blocks.size() == 0) begin
            $error("result with no block pending: magnitude_sq %0d", m_magnitude_sq);
            mismatches++;
        end else begin
            want = expected_blocks.pop_front();
            if (m_magnitude_sq !== want.magnitude_sq) begin
                $error("magnitude_sq: expected %0d, got %0d", want.magnitude_sq,
                       m_magnitude_sq);
                mismatches++;
            end
            if (m_tone_present !== want.tone_present) begin
                $error("tone_present: expected %0d, got %0d", want.tone_present,
                       m_tone_present);
                mismatches++;
            end
            if (m_changed !== want.changed) begin
                $error("changed: expected %0d, got %0d", want.changed, m_changed);
                mismatches++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.coeff        = COEFF_RST;
            regs.threshold    = THRESHOLD_RST;
            regs.block_length = BLOCK_LENGTH_RST;
            regs.hold_blocks  = HOLD_BLOCKS_RST;
            recent    = '0;
            older     = '0;
            count     = '0;
            hold_left = '0;
            expected_blocks.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_COEFF:        regs.coeff        = cfg_data[COEFF_W-1:0];
                    REG_THRESHOLD:    regs.threshold    = cfg_data[THRESH_W-1:0];
                    REG_BLOCK_LENGTH: regs.block_length = cfg_data[BLEN_W-1:0];
                    REG_HOLD_BLOCKS:  regs.hold_blocks  = cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                take_sample(s_sample);
            end
        end
        fail_count <= mismatches;
        pending    <= expected_blocks.size();
    end

endmodule

FILE: bench/goertzel_tone_detector_unit_tb.sv
`timescale 1ns / 1ps

module goertzel_tone_detector_unit_tb;
    import gtd_pkg::*;

    localparam int RANDOM_ITEMS = 900;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum int {
        SHAPE_SILENT,
        SHAPE_QUIET,
        SHAPE_NOISE,
        SHAPE_RAIL,
        SHAPE_ALTERNATE,
        SHAPE_CONST
    } sample_shape_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [MAG_W-1:0]           m_magnitude_sq;
    logic                       m_tone_present;
    logic                       m_changed;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   samples_sent = 0;
    logic long_hold_req = 1'b0;
    bit   tx_steady = 1'b0;
    bit   rx_steady = 1'b0;

    goertzel_tone_detector_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_magnitude_sq (m_magnitude_sq),
        .m_tone_present (m_tone_present),
        .m_changed      (m_changed),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    gtd_block_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_magnitude_sq (m_magnitude_sq),
        .m_tone_present (m_tone_present),
        .m_changed      (m_changed),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
        int gap;
        if ($urandom_range(0, 39) == 0) begin
            tx_steady = !tx_steady;
        end
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
    endtask

    // stop offering samples, wait for every block result, let the datapath settle
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic signed [COEFF_W-1:0] c,
                                  input logic [THRESH_W-1:0] thr,
                                  input logic [BLEN_W-1:0] bl,
                                  input logic [HOLD_W-1:0] hb);
        drain_results();
        cfg_put(REG_COEFF, CFG_DATA_W'(unsigned'(c)));
        cfg_put(REG_THRESHOLD, CFG_DATA_W'(thr));
        cfg_put(REG_BLOCK_LENGTH, CFG_DATA_W'(bl));
        cfg_put(REG_HOLD_BLOCKS, CFG_DATA_W'(hb));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input sample_shape_t shape,
                                                               input int idx,
                                                               input logic [SAMPLE_W-1:0] konst);
        logic signed [SAMPLE_W-1:0] v;
        case (shape)
            SHAPE_SILENT:    v = '0;
            SHAPE_QUIET:     v = SAMPLE_W'($urandom_range(0, 200)) - 16'sd100;
            SHAPE_NOISE:     v = SAMPLE_W'($urandom());
            SHAPE_RAIL:      v = ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
            SHAPE_ALTERNATE: v = (idx % 2 == 0) ? 16'sh7fff : 16'sh8000;
            default:         v = konst;
        endcase
        return v;
    endfunction

    initial begin : result_sink
        int gap;
        bit held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            if ($urandom_range(0, 31) == 0) begin
                rx_steady = !rx_steady;
            end
            gap = rx_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : stimulus
        sample_shape_t              shape;
        logic signed [COEFF_W-1:0]  c_pick;
        logic [THRESH_W-1:0]        t_pick;
        logic [BLEN_W-1:0]          bl_pick;
        logic [HOLD_W-1:0]          hb_pick;
        logic [SAMPLE_W-1:0]        konst;
        int                         eff;
        int                         blocks;
        int                         base;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one sample per block, zero threshold, zero hold count
        apply_settings(16'sh7fff, '0, 10'd1, 4'd0);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sd0);
        send_sample(16'sd1);
        send_sample(-16'sd1);

        // most negative coefficient, unreachable threshold, flag drops
        apply_settings(16'sh8000, '1, 10'd4, 4'd15);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);

        // zero block length acts as one
        apply_settings(16'sd0, 48'd1, 10'd0, 4'd2);
        send_sample(16'sd100);
        send_sample(16'sd0);
        send_sample(16'sd0);

        // block length shrunk below the current count
        apply_settings(16'sd16000, 48'd1000, 10'd10, 4'd1);
        repeat (5) send_sample(SAMPLE_W'($urandom()));
        apply_settings(16'sd16000, 48'd1000, 10'd3, 4'd1);
        send_sample(16'sd1234);

        // output held off while samples keep coming
        apply_settings(SAMPLE_W'($urandom()), 48'd5000000, 10'd1, 4'd3);
        long_hold_req <= 1'b1;
        repeat (30) send_sample(SAMPLE_W'($urandom()));

        base = samples_sent;
        while (samples_sent - base < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       c_pick = 16'sh7fff;
                1:       c_pick = 16'sh8000;
                2:       c_pick = '0;
                default: c_pick = COEFF_W'($urandom());
            endcase
            case ($urandom_range(0, 9))
                0:       t_pick = '0;
                1:       t_pick = '1;
                default: begin
                    t_pick = THRESH_W'({$urandom(), $urandom()});
                    t_pick = t_pick >> $urandom_range(0, 47);
                end
            endcase
            case ($urandom_range(0, 23))
                0:       bl_pick = '0;
                1:       bl_pick = BLEN_W'($urandom_range(100, 300));
                default: bl_pick = BLEN_W'($urandom_range(1, 12));
            endcase
            hb_pick = HOLD_W'($urandom_range(0, 15));
            apply_settings(c_pick, t_pick, bl_pick, hb_pick);
            eff = (bl_pick == '0) ? 1 : int'(bl_pick);
            blocks = (eff > 12) ? 1 : $urandom_range(2, 10);
            for (int b = 0; b < blocks; b++) begin
                shape = sample_shape_t'($urandom_range(0, 5));
                konst = SAMPLE_W'($urandom());
                for (int i = 0; i < eff; i++) begin
                    send_sample(pick_sample(shape, i, konst));
                end
            end
            // partial block carried into the next setting
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(0, eff - 1)) send_sample(SAMPLE_W'($urandom()));
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/gtd_pkg.sv
rtl/gtd_datapath.sv
rtl/goertzel_tone_detector_unit.sv
bench/gtd_block_checker.sv
bench/goertzel_tone_detector_unit_tb.sv
